// ===== sv/dtq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline timer queue package
// Operation and result codes, field widths and fixed constants shared by the
// timer queue modules.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int ID_W    = 4;
  localparam int TAG_W   = 8;
  localparam int DLY_W   = 32;
  localparam int NOW_W   = 48;
  localparam int DL_W    = 50;
  localparam int MS_W    = 10;
  localparam int PROD_W  = DLY_W + MS_W;
  localparam int MAX_OUT = 16;
  localparam int CNT_W   = 5;

  localparam logic [MS_W-1:0] US_PER_MS = MS_W'(1000);

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_POLL   = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_SET_OK      = 3'd0,
    K_SET_REFUSED = 3'd1,
    K_CANCEL_OK   = 3'd2,
    K_CANCEL_NP   = 3'd3,
    K_EXPIRED     = 3'd4,
    K_NONE_DUE    = 3'd5
  } kind_t;

  typedef struct packed {
    logic ins;
    logic del;
  } row_cmd_t;

endpackage

// ===== sv/deadline_timer_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline timer queue
// Up to TIMERS one-shot timers kept in deadline order, with set, cancel and
// poll requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; the block then stays
// busy until the cycle that carries its last result, so the next request can
// be taken at the edge that ends that cycle. Each result appears for one
// cycle with out_valid high, and out_last marks the final result of a request.
// The receiver cannot stall; results are never held back.
// Request flow:
//   cancel: answered at dispatch when not pending, else after a linear search
//           for the slot in the order row.
//   set: answered at dispatch when refused, else multiply, add, an optional
//        unlink search when re-arming, then an insertion search that reads one
//        stored deadline at a time through the registered slot memory and the
//        shared comparator.
//   poll: answered at dispatch when the queue is empty, else a walk from the
//         head of the order row that expires each due timer until all pending
//         timers expire, MAX_OUT have expired or a later deadline is found.
// The unused operation code gives no result and goes back to idle after
// dispatch. Reset clears all pending timers and the result strobe; the slot
// memory and the order row need no clearing since only pending slots are read.
// ----------------------------------------------------------------------------
module deadline_timer_queue
  import dtq_pkg::*;
#(
  parameter int TIMERS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [ID_W-1:0]    in_timer_id,
  input  logic [DLY_W-1:0]   in_delay_ms,
  input  logic [TAG_W-1:0]   in_handler_tag,
  input  logic               in_ignore_if_pending,
  input  logic [NOW_W-1:0]   in_now_us,
  output logic               out_valid,
  output logic [2:0]         out_kind,
  output logic [ID_W-1:0]    out_expired_id,
  output logic [TAG_W-1:0]   out_expired_tag,
  output logic               out_last
);

  localparam int SW    = $clog2(TIMERS);
  localparam int OW    = $clog2(TIMERS + 1);
  localparam int MEM_W = DL_W + TAG_W;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_DISP  = 10'b0000000010,
    ST_ADD   = 10'b0000000100,
    ST_USRCH = 10'b0000001000,
    ST_LADDR = 10'b0000010000,
    ST_LCMP  = 10'b0000100000,
    ST_INS   = 10'b0001000000,
    ST_PADDR = 10'b0010000000,
    ST_PCMP  = 10'b0100000000,
    ST_PFIN  = 10'b1000000000
  } state_t;

  state_t              state_r, state_nxt;
  op_t                 op_r;
  logic [ID_W-1:0]     id_r;
  logic [DLY_W-1:0]    delay_r;
  logic [TAG_W-1:0]    htag_r;
  logic                ign_r;
  logic [NOW_W-1:0]    now_r;
  logic [PROD_W-1:0]   prod_r;
  logic [DL_W-1:0]     dl_new_r;
  logic [OW-1:0]       p_r, p_nxt;
  logic [OW-1:0]       occ_r, occ_nxt;
  logic [TIMERS-1:0]   pending_r, pending_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                held_v_r, held_v_nxt;
  logic [SW-1:0]       held_id_r, held_id_nxt;
  logic [TAG_W-1:0]    held_tag_r, held_tag_nxt;
  logic                out_valid_r, out_valid_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic [TAG_W-1:0]    out_tag_r, out_tag_nxt;
  logic                out_last_r, out_last_nxt;

  logic [SW-1:0]       slot;
  logic                in_range;
  logic                pend_id;
  logic [DL_W-1:0]     dl_sum;
  row_cmd_t            row_cmd;
  logic [SW-1:0]       row_pos;
  logic [SW-1:0]       rd_id;
  logic                mem_we;
  logic [MEM_W-1:0]    mem_rdata;
  logic [DL_W-1:0]     mem_dl;
  logic [TAG_W-1:0]    mem_tag;
  logic [DL_W-1:0]     cmp_ref;
  logic                cmp_le;
  logic                accept;

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);
  assign slot     = SW'(id_r);
  assign in_range = (32'(id_r) < 32'(TIMERS));
  assign pend_id  = in_range && pending_r[slot];
  assign dl_sum   = DL_W'(now_r) + DL_W'(prod_r);
  assign mem_dl   = mem_rdata[MEM_W-1:TAG_W];
  assign mem_tag  = mem_rdata[TAG_W-1:0];
  assign cmp_ref  = (state_r == ST_LCMP) ? dl_new_r : DL_W'(now_r);
  assign cmp_le   = (mem_dl <= cmp_ref);

  dtq_slot_mem #(
    .DEPTH (TIMERS),
    .W     (MEM_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot),
    .wdata ({dl_sum, htag_r}),
    .raddr (rd_id),
    .rdata (mem_rdata)
  );

  dtq_order #(
    .DEPTH (TIMERS),
    .SW    (SW)
  ) u_order (
    .clk   (clk),
    .cmd   (row_cmd),
    .pos   (row_pos),
    .id    (slot),
    .rd_id (rd_id)
  );

  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    occ_nxt       = occ_r;
    pending_nxt   = pending_r;
    cnt_nxt       = cnt_r;
    held_v_nxt    = held_v_r;
    held_id_nxt   = held_id_r;
    held_tag_nxt  = held_tag_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_tag_nxt   = out_tag_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    row_cmd       = '0;
    row_pos       = p_r[SW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        p_nxt      = '0;
        cnt_nxt    = '0;
        held_v_nxt = 1'b0;
        out_id_nxt  = id_r;
        out_tag_nxt = '0;
        out_last_nxt = 1'b1;
        case (op_r)
          OP_SET: begin
            if (!in_range || (pend_id && ign_r)) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = K_SET_REFUSED;
              state_nxt     = ST_IDLE;
            end else begin
              state_nxt = ST_ADD;
            end
          end
          OP_CANCEL: begin
            if (!pend_id) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = K_CANCEL_NP;
              state_nxt     = ST_IDLE;
            end else begin
              state_nxt = ST_USRCH;
            end
          end
          OP_POLL: begin
            if (occ_r == '0) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = K_NONE_DUE;
              out_id_nxt    = '0;
              state_nxt     = ST_IDLE;
            end else begin
              state_nxt = ST_PADDR;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_ADD: begin
        mem_we    = 1'b1;
        state_nxt = pend_id ? ST_USRCH : ST_LADDR;
      end
      ST_USRCH: begin
        if (rd_id == slot) begin
          row_cmd.del       = 1'b1;
          occ_nxt           = occ_r - OW'(1);
          pending_nxt[slot] = 1'b0;
          p_nxt             = '0;
          if (op_r == OP_SET) begin
            state_nxt = ST_LADDR;
          end else begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = K_CANCEL_OK;
            out_id_nxt    = id_r;
            out_tag_nxt   = '0;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          p_nxt = p_r + OW'(1);
        end
      end
      ST_LADDR: begin
        state_nxt = (p_r >= occ_r) ? ST_INS : ST_LCMP;
      end
      ST_LCMP: begin
        if (cmp_le) begin
          p_nxt     = p_r + OW'(1);
          state_nxt = ST_LADDR;
        end else begin
          state_nxt = ST_INS;
        end
      end
      ST_INS: begin
        row_cmd.ins       = 1'b1;
        occ_nxt           = occ_r + OW'(1);
        pending_nxt[slot] = 1'b1;
        out_valid_nxt     = 1'b1;
        out_kind_nxt      = K_SET_OK;
        out_id_nxt        = id_r;
        out_tag_nxt       = '0;
        out_last_nxt      = 1'b1;
        state_nxt         = ST_IDLE;
      end
      ST_PADDR: begin
        state_nxt = ST_PCMP;
      end
      ST_PCMP: begin
        if (cmp_le) begin
          row_cmd.del        = 1'b1;
          row_pos            = '0;
          occ_nxt            = occ_r - OW'(1);
          pending_nxt[rd_id] = 1'b0;
          cnt_nxt            = cnt_r + CNT_W'(1);
          if (held_v_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = K_EXPIRED;
            out_id_nxt    = ID_W'(held_id_r);
            out_tag_nxt   = held_tag_r;
            out_last_nxt  = 1'b0;
          end
          held_v_nxt   = 1'b1;
          held_id_nxt  = rd_id;
          held_tag_nxt = mem_tag;
          if ((cnt_r + CNT_W'(1)) < CNT_W'(MAX_OUT) && occ_r > OW'(1)) begin
            state_nxt = ST_PADDR;
          end else begin
            state_nxt = ST_PFIN;
          end
        end else begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (held_v_r) begin
            out_kind_nxt = K_EXPIRED;
            out_id_nxt   = ID_W'(held_id_r);
            out_tag_nxt  = held_tag_r;
          end else begin
            out_kind_nxt = K_NONE_DUE;
            out_id_nxt   = '0;
            out_tag_nxt  = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_PFIN: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = K_EXPIRED;
        out_id_nxt    = ID_W'(held_id_r);
        out_tag_nxt   = held_tag_r;
        out_last_nxt  = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      p_r         <= '0;
      occ_r       <= '0;
      pending_r   <= '0;
      cnt_r       <= '0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p_r         <= p_nxt;
      occ_r       <= occ_nxt;
      pending_r   <= pending_nxt;
      cnt_r       <= cnt_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op_t'(in_operation);
      id_r    <= in_timer_id;
      delay_r <= in_delay_ms;
      htag_r  <= in_handler_tag;
      ign_r   <= in_ignore_if_pending;
      now_r   <= in_now_us;
    end
    prod_r <= PROD_W'(delay_r) * PROD_W'(US_PER_MS);
    if (state_r == ST_ADD) begin
      dl_new_r <= dl_sum;
    end
    held_id_r  <= held_id_nxt;
    held_tag_r <= held_tag_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_tag_r  <= out_tag_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_expired_id  = out_id_r;
  assign out_expired_tag = out_tag_r;
  assign out_last        = out_last_r;

`ifndef SYNTH
  a_occ_matches_pending: assert property (@(posedge clk) disable iff (!rst_n)
    32'(occ_r) == $countones(pending_r))
    else $error("occupancy differs from the number of pending timers");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(occ_r) <= 32'(TIMERS))
    else $error("occupancy exceeds the timer count");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken without the block going busy");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != K_EXPIRED) |-> out_last)
    else $error("non-expiry result not marked as the final result");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("poll run ended without its final result");
`endif

endmodule

// ===== sv/dtq_slot_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer slot memory
// Per-slot deadline and handler tag, one write port and one registered read.
// ----------------------------------------------------------------------------
module dtq_slot_mem #(
  parameter int DEPTH = 16,
  parameter int W     = 58
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/dtq_order.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline order row
// Row of slot numbers kept in deadline order; inserts open a gap and deletes
// close one, with all shifted entries taking their neighbors in parallel.
// ----------------------------------------------------------------------------
module dtq_order
  import dtq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int SW    = 4
) (
  input  logic          clk,
  input  row_cmd_t      cmd,
  input  logic [SW-1:0] pos,
  input  logic [SW-1:0] id,
  output logic [SW-1:0] rd_id
);

  logic [SW-1:0] row_r   [DEPTH];
  logic [SW-1:0] row_nxt [DEPTH];

  always_comb begin
    for (int q = 0; q < DEPTH; q++) begin
      row_nxt[q] = row_r[q];
      if (cmd.ins) begin
        if (SW'(q) == pos) begin
          row_nxt[q] = id;
        end else if (q > 0 && SW'(q) > pos) begin
          row_nxt[q] = row_r[SW'(q - 1)];
        end
      end else if (cmd.del && q < DEPTH - 1 && SW'(q) >= pos) begin
        row_nxt[q] = row_r[SW'(q + 1)];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int q = 0; q < DEPTH; q++) begin
      row_r[q] <= row_nxt[q];
    end
  end

  assign rd_id = row_r[pos];

endmodule
